>>> sv/tis_pkg.sv
// Shared constants, codes and types of the tickless idle sleep timer.
`timescale 1ns / 1ps
package tis_pkg;

   // Counter and field widths
   localparam int COUNTER_BITS   = 24;
   localparam int TICKS_BITS     = 32;
   localparam int MIN_BITS       = 16;
   localparam int CSR_INDEX_BITS = 8;
   localparam int MUL_CNT_BITS   = $clog2(TICKS_BITS);
   localparam int DIV_CNT_BITS   = $clog2(COUNTER_BITS);

   typedef logic [COUNTER_BITS-1:0]   cnt_type;
   typedef logic [TICKS_BITS-1:0]     ticks_type;
   typedef logic [MIN_BITS-1:0]       min_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam cnt_type CNT_MAX        = {COUNTER_BITS{1'b1}};
   localparam cnt_type PERIOD_RESET   = cnt_type'(72000);
   localparam min_type MIN_IDLE_RESET = min_type'(2);

   // Register indexes
   localparam csr_index_type CSR_TICK_PERIOD = csr_index_type'(0);
   localparam csr_index_type CSR_MIN_IDLE    = csr_index_type'(1);

   // Item operation codes
   localparam logic OP_ENTER = 1'b0;
   localparam logic OP_EXIT  = 1'b1;

   // Serial multiplier command and status
   typedef struct packed {
      logic      start;
      ticks_type multiplier;
      cnt_type   multiplicand;
      cnt_type   addend;
   } mul_cmd_type;

   typedef struct packed {
      logic    done;
      cnt_type total;
   } mul_res_type;

   // Serial divider command and status
   typedef struct packed {
      logic    start;
      cnt_type dividend;
      cnt_type divisor;
   } div_cmd_type;

   typedef struct packed {
      logic    done;
      cnt_type quotient;
   } div_res_type;

   // One result item
   typedef struct packed {
      logic    armed;
      cnt_type oneshot_load;
      cnt_type ticks_slept;
      cnt_type restore_reload;
      logic    restart_periodic;
   } result_type;

endpackage

>>> sv/tis_req_if.sv
// Input item channel of the tickless idle sleep timer.
`timescale 1ns / 1ps
interface tis_req_if
   import tis_pkg::*;
();
   logic      valid;
   logic      ready;
   logic      op;
   ticks_type idle_ticks;
   cnt_type   count_value;
   cnt_type   current_reload;

   modport source (output valid, op, idle_ticks, count_value, current_reload,
                   input ready);
   modport sink   (input valid, op, idle_ticks, count_value, current_reload,
                   output ready);
endinterface

>>> sv/tis_rsp_if.sv
// Result item channel of the tickless idle sleep timer.
`timescale 1ns / 1ps
interface tis_rsp_if
   import tis_pkg::*;
();
   logic    valid;
   logic    ready;
   logic    armed;
   cnt_type oneshot_load;
   cnt_type ticks_slept;
   cnt_type restore_reload;
   logic    restart_periodic;

   modport source (output valid, armed, oneshot_load, ticks_slept, restore_reload,
                   restart_periodic, input ready);
   modport sink   (input valid, armed, oneshot_load, ticks_slept, restore_reload,
                   restart_periodic, output ready);
endinterface

>>> sv/tis_csr_if.sv
// Register write channel of the tickless idle sleep timer.
`timescale 1ns / 1ps
interface tis_csr_if
   import tis_pkg::*;
();
   logic          valid;
   logic          ready;
   csr_index_type index;
   cnt_type       data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/tis_mul.sv
// Bit-serial saturating multiply-add: total = addend + multiplier * multiplicand.
`timescale 1ns / 1ps
module tis_mul
   import tis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_res_type res
);

   localparam logic [MUL_CNT_BITS-1:0] LAST_STEP = MUL_CNT_BITS'(TICKS_BITS - 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [MUL_CNT_BITS-1:0] step_ff;
   cnt_type                 acc_ff, acc_in;
   logic                    sat_ff, sat_in;
   ticks_type               mplier_ff;
   cnt_type                 mcand_ff;
   cnt_type                 addend_ff;
   logic [COUNTER_BITS+1:0] step_sum;
   logic [COUNTER_BITS:0]   final_sum;

   // Double the accumulator and add the multiplicand on a set multiplier bit
   always_comb begin
      step_sum = {1'b0, acc_ff, 1'b0}
               + ((COUNTER_BITS+2)'(mcand_ff) & {(COUNTER_BITS+2){mplier_ff[TICKS_BITS-1]}});
      acc_in   = step_sum[COUNTER_BITS-1:0];
      sat_in   = sat_ff | (step_sum[COUNTER_BITS+1:COUNTER_BITS] != 2'b00);
   end

   // Sequence the steps, MSB of the multiplier first
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (cmd.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Hold operands and the running product
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         acc_ff    <= '0;
         sat_ff    <= 1'b0;
         mplier_ff <= cmd.multiplier;
         mcand_ff  <= cmd.multiplicand;
         addend_ff <= cmd.addend;
      end else if (busy_ff) begin
         acc_ff    <= acc_in;
         sat_ff    <= sat_in;
         mplier_ff <= {mplier_ff[TICKS_BITS-2:0], 1'b0};
      end
   end

   // Add the remaining count and clamp to the counter range
   assign final_sum = {1'b0, acc_ff} + {1'b0, addend_ff};
   assign res.done  = done_ff;
   assign res.total = (sat_ff || final_sum[COUNTER_BITS]) ? CNT_MAX
                                                          : final_sum[COUNTER_BITS-1:0];

endmodule

>>> sv/tis_div.sv
// Restoring bit-serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module tis_div
   import tis_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_res_type res
);

   localparam logic [DIV_CNT_BITS-1:0] LAST_STEP = DIV_CNT_BITS'(COUNTER_BITS - 1);

   logic                    busy_ff;
   logic                    done_ff;
   logic [DIV_CNT_BITS-1:0] step_ff;
   cnt_type                 rem_ff, rem_in;
   cnt_type                 quot_ff;
   cnt_type                 divisor_ff;
   logic                    qbit;
   logic [COUNTER_BITS:0]   trial;
   logic [COUNTER_BITS:0]   diff;

   // Shift in the next dividend bit and try a subtract
   always_comb begin
      trial  = {rem_ff, quot_ff[COUNTER_BITS-1]};
      diff   = trial - {1'b0, divisor_ff};
      qbit   = (trial >= {1'b0, divisor_ff});
      rem_in = qbit ? diff[COUNTER_BITS-1:0] : trial[COUNTER_BITS-1:0];
   end

   // Sequence the steps
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= busy_ff && (step_ff == LAST_STEP);
         if (cmd.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == LAST_STEP) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // Dividend shifts out as quotient bits shift in
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff     <= '0;
         quot_ff    <= cmd.dividend;
         divisor_ff <= cmd.divisor;
      end else if (busy_ff) begin
         rem_ff  <= rem_in;
         quot_ff <= {quot_ff[COUNTER_BITS-2:0], qbit};
      end
   end

   assign res.done     = done_ff;
   assign res.quotient = quot_ff;

endmodule

>>> sv/tickless_idle_sleep_timer_core.sv
// Top level of the tickless idle sleep timer: control, state and result register.
`timescale 1ns / 1ps
// One item in flight at a time. An enter item that arms runs the bit-serial
// multiply-add over the 32 bits of the tick count before it loads the result
// register; an exit item that ends an active sleep runs the 24-step serial
// divider first; an enter below the minimum and an exit while not sleeping use
// neither unit. Each result then waits until the result register is free, that
// is until the previous result is taken. The block is ready for the next item in
// the cycle after the result is placed in the output register, even while that
// result still waits to be taken. Register writes are taken at any time (ready is
// always high) and are meant for idle periods only. The tick period register
// reads a value of zero as one when dividing.
module tickless_idle_sleep_timer_core
   import tis_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   tis_req_if.sink   req_ch,
   tis_rsp_if.source rsp_ch,
   tis_csr_if.sink   csr_ch
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_MUL  = 4'b0010,
      S_DIV  = 4'b0100,
      S_WAIT = 4'b1000
   } state_type;

   state_type   state_ff, state_in;
   cnt_type     period_ff;
   min_type     min_idle_ff;
   logic        sleep_active_ff, sleep_active_in;
   cnt_type     prog_load_ff, prog_load_in;
   cnt_type     saved_reload_ff, saved_reload_in;
   cnt_type     hold_reload_ff, hold_reload_in;
   result_type  pend_ff, pend_in;
   result_type  out_ff, out_in;
   logic        out_valid_ff, out_valid_in;
   mul_cmd_type mul_cmd;
   mul_res_type mul_res;
   div_cmd_type div_cmd;
   div_res_type div_res;
   logic        req_acc;
   logic        enough_ticks;
   logic [COUNTER_BITS:0] slept_total;
   cnt_type     mul_total;

   assign req_acc      = req_ch.valid && req_ch.ready;
   assign enough_ticks = (req_ch.idle_ticks >= ticks_type'(min_idle_ff));
   assign slept_total  = {1'b0, prog_load_ff} + 1'b1;
   assign mul_total    = (mul_res.total == '0) ? cnt_type'(1) : mul_res.total;

   // Operands for the serial units
   always_comb begin
      mul_cmd.start        = 1'b0;
      mul_cmd.multiplier   = (req_ch.idle_ticks > ticks_type'(1))
                           ? ticks_type'(req_ch.idle_ticks - ticks_type'(1)) : '0;
      mul_cmd.multiplicand = period_ff;
      mul_cmd.addend       = req_ch.count_value;
      div_cmd.start        = 1'b0;
      div_cmd.dividend     = ({1'b0, req_ch.count_value} > slept_total) ? '0
                           : cnt_type'(slept_total - {1'b0, req_ch.count_value});
      div_cmd.divisor      = (period_ff == '0) ? cnt_type'(1) : period_ff;
      if (req_acc && (state_ff == S_IDLE)) begin
         mul_cmd.start = (req_ch.op == OP_ENTER) && enough_ticks;
         div_cmd.start = (req_ch.op == OP_EXIT) && sleep_active_ff;
      end
   end

   // Sequence each item and place its result
   always_comb begin
      state_in        = state_ff;
      sleep_active_in = sleep_active_ff;
      prog_load_in    = prog_load_ff;
      saved_reload_in = saved_reload_ff;
      hold_reload_in  = hold_reload_ff;
      pend_in         = pend_ff;
      out_in          = out_ff;
      out_valid_in    = out_valid_ff && !rsp_ch.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               pend_in  = '0;
               state_in = S_WAIT;
               if (req_ch.op == OP_ENTER) begin
                  if (enough_ticks) begin
                     hold_reload_in = req_ch.current_reload;
                     state_in       = S_MUL;
                  end
               end else if (sleep_active_ff) begin
                  sleep_active_in = 1'b0;
                  state_in        = S_DIV;
               end
            end
         end
         S_MUL: begin
            if (mul_res.done) begin
               prog_load_in         = mul_total - 1'b1;
               saved_reload_in      = hold_reload_ff;
               sleep_active_in      = 1'b1;
               pend_in.armed        = 1'b1;
               pend_in.oneshot_load = mul_total - 1'b1;
               state_in             = S_WAIT;
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               pend_in.ticks_slept      = (div_res.quotient == '0) ? cnt_type'(1)
                                                                   : div_res.quotient;
               pend_in.restore_reload   = saved_reload_ff;
               pend_in.restart_periodic = 1'b1;
               state_in                 = S_WAIT;
            end
         end
         S_WAIT: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state and sleep state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         out_valid_ff    <= 1'b0;
         sleep_active_ff <= 1'b0;
         prog_load_ff    <= '0;
         saved_reload_ff <= '0;
      end else begin
         state_ff        <= state_in;
         out_valid_ff    <= out_valid_in;
         sleep_active_ff <= sleep_active_in;
         prog_load_ff    <= prog_load_in;
         saved_reload_ff <= saved_reload_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      hold_reload_ff <= hold_reload_in;
      pend_ff        <= pend_in;
      out_ff         <= out_in;
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= PERIOD_RESET;
         min_idle_ff <= MIN_IDLE_RESET;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (csr_ch.index)
            CSR_TICK_PERIOD: period_ff   <= csr_ch.data;
            CSR_MIN_IDLE:    min_idle_ff <= csr_ch.data[MIN_BITS-1:0];
            default: ;
         endcase
      end
   end

   tis_mul u_mul (
      .clock (clock),
      .reset (reset),
      .cmd   (mul_cmd),
      .res   (mul_res)
   );

   tis_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .res   (div_res)
   );

   // Drive the channels
   assign req_ch.ready            = (state_ff == S_IDLE);
   assign csr_ch.ready            = 1'b1;
   assign rsp_ch.valid            = out_valid_ff;
   assign rsp_ch.armed            = out_ff.armed;
   assign rsp_ch.oneshot_load     = out_ff.oneshot_load;
   assign rsp_ch.ticks_slept      = out_ff.ticks_slept;
   assign rsp_ch.restore_reload   = out_ff.restore_reload;
   assign rsp_ch.restart_periodic = out_ff.restart_periodic;

   // An armed result waiting to be placed means sleep has begun
   a_armed_sleeping: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) && pend_ff.armed |-> sleep_active_ff)
      else $error("armed result pending while not sleeping");

   // A restart result waiting to be placed means sleep has ended
   a_restart_awake: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WAIT) && pend_ff.restart_periodic |-> !sleep_active_ff)
      else $error("restart result pending while still sleeping");

   // A restart always reports at least one elapsed tick and never arms
   a_restart_ticks: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.restart_periodic |-> (out_ff.ticks_slept != '0)
                                                 && !out_ff.armed)
      else $error("restart result with zero ticks or armed");

endmodule

>>> sim/tis_sleep_checker.sv
// Checker for the tickless idle sleep timer: mirrors its state, predicts and compares results.
`timescale 1ns / 1ps
module tis_sleep_checker
   import tis_pkg::*;
(
   input  logic clock,
   input  logic reset,
   tis_req_if   req_mon,
   tis_rsp_if   rsp_mon,
   tis_csr_if   csr_mon,
   output int   mismatches,
   output int   outstanding,
   output int   sleeps_armed,
   output int   loads_clipped,
   output int   wakeups,
   output int   short_idles
);
   localparam int REPORT_LIMIT = 10;

   // Mirror of the registers and of the sleep state
   cnt_type period_cfg;
   min_type min_idle_cfg;
   logic    asleep;
   cnt_type load_now;
   cnt_type reload_kept;

   result_type awaited_results[$];

   // Work out the result of one item and advance the mirrored state
   function automatic result_type sleep_timer_outcome(logic op, ticks_type ticks,
                                                      cnt_type count, cnt_type reload);
      result_type  r;
      logic [63:0] span;
      logic [63:0] passed;
      cnt_type     divisor;
      r = '0;
      if (op == OP_ENTER) begin
         if (ticks >= ticks_type'(min_idle_cfg)) begin
            span = 64'(count);
            if (ticks > ticks_type'(1)) begin
               span = span + (64'(ticks) - 64'd1) * 64'(period_cfg);
            end
            if (span > 64'(CNT_MAX)) begin
               span = 64'(CNT_MAX);
               loads_clipped++;
            end
            if (span == 64'd0) begin
               span = 64'd1;
            end
            reload_kept = reload;
            load_now = cnt_type'(span - 64'd1);
            asleep = 1'b1;
            r.armed = 1'b1;
            r.oneshot_load = load_now;
            sleeps_armed++;
         end else begin
            short_idles++;
         end
      end else if (asleep) begin
         span = 64'(load_now) + 64'd1;
         passed = (64'(count) > span) ? 64'd0 : span - 64'(count);
         divisor = (period_cfg == '0) ? cnt_type'(1) : period_cfg;
         passed = passed / 64'(divisor);
         if (passed == 64'd0) begin
            passed = 64'd1;
         end
         r.ticks_slept = cnt_type'(passed);
         r.restore_reload = reload_kept;
         r.restart_periodic = 1'b1;
         asleep = 1'b0;
         wakeups++;
      end
      return r;
   endfunction

   // Compare one delivered item with the oldest prediction
   task automatic check_result(result_type got);
      result_type want;
      if (awaited_results.size() == 0) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display({"[%0t] result item with no prediction pending: ",
                      "armed=%0d load=%h elapsed=%0d restore=%h restart=%0d"},
                     $time, got.armed, got.oneshot_load, got.ticks_slept,
                     got.restore_reload, got.restart_periodic);
         end
         return;
      end
      want = awaited_results.pop_front();
      if (got.armed !== want.armed || got.oneshot_load !== want.oneshot_load ||
          got.ticks_slept !== want.ticks_slept ||
          got.restore_reload !== want.restore_reload ||
          got.restart_periodic !== want.restart_periodic) begin
         mismatches++;
         if (mismatches <= REPORT_LIMIT) begin
            $display({"[%0t] mismatch: expected armed=%0d load=%h elapsed=%0d ",
                      "restore=%h restart=%0d"},
                     $time, want.armed, want.oneshot_load, want.ticks_slept,
                     want.restore_reload, want.restart_periodic);
            $display("            got      armed=%0d load=%h elapsed=%0d restore=%h restart=%0d",
                     got.armed, got.oneshot_load, got.ticks_slept,
                     got.restore_reload, got.restart_periodic);
         end
      end
   endtask

   // Watch all three channels at each rising edge
   always @(posedge clock) begin
      if (reset) begin
         period_cfg = PERIOD_RESET;
         min_idle_cfg = MIN_IDLE_RESET;
         asleep = 1'b0;
         load_now = '0;
         reload_kept = '0;
         awaited_results.delete();
         mismatches = 0;
         sleeps_armed = 0;
         loads_clipped = 0;
         wakeups = 0;
         short_idles = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            check_result('{armed: rsp_mon.armed, oneshot_load: rsp_mon.oneshot_load,
                           ticks_slept: rsp_mon.ticks_slept,
                           restore_reload: rsp_mon.restore_reload,
                           restart_periodic: rsp_mon.restart_periodic});
         end
         if (csr_mon.valid && csr_mon.ready) begin
            if (csr_mon.index == CSR_TICK_PERIOD) begin
               period_cfg = csr_mon.data;
            end else if (csr_mon.index == CSR_MIN_IDLE) begin
               min_idle_cfg = min_type'(csr_mon.data);
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            awaited_results.push_back(sleep_timer_outcome(req_mon.op, req_mon.idle_ticks,
                                                          req_mon.count_value,
                                                          req_mon.current_reload));
         end
      end
      outstanding = awaited_results.size();
   end

endmodule

>>> sim/tickless_idle_sleep_timer_core_tb.sv
// Testbench top for the tickless idle sleep timer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tickless_idle_sleep_timer_core_tb
   import tis_pkg::*;
();

   localparam int RESET_CYCLES   = 11;
   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int STALL_CYCLES   = 300;
   localparam int SEGMENT_ITEMS  = 130;
   localparam int SEGMENTS       = 5;
   localparam int PHASES         = 3;
   localparam csr_index_type CSR_UNMAPPED = csr_index_type'(8'hFF);

   logic clock = 1'b0;
   logic reset;

   tis_req_if req_ch();
   tis_rsp_if rsp_ch();
   tis_csr_if csr_ch();

   int mismatches;
   int outstanding;
   int sleeps_armed;
   int loads_clipped;
   int wakeups;
   int short_idles;

   // Stimulus controls and bookkeeping
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   logic        rsp_holding;
   event        hold_rsp;
   int          items_sent = 0;
   int          settings_used = 1;
   cnt_type     cfg_period = PERIOD_RESET;
   min_type     cfg_min = MIN_IDLE_RESET;
   int unsigned cycle_count = 0;

   tickless_idle_sleep_timer_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tis_sleep_checker sleep_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_mon       (csr_ch),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .sleeps_armed  (sleeps_armed),
      .loads_clipped (loads_clipped),
      .wakeups       (wakeups),
      .short_idles   (short_idles)
   );

   always #1 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d results still due",
                  cycle_count, outstanding);
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Drive the result side ready, with random stalls
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_ch.ready <= !rsp_holding && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Hold off the result side for a long stretch on request
   initial begin
      rsp_holding <= 1'b0;
      forever begin
         @(hold_rsp);
         rsp_holding <= 1'b1;
         repeat (STALL_CYCLES) @(posedge clock);
         rsp_holding <= 1'b0;
      end
   end

   // Offer one item, idling first at random; returns on the accepting edge
   task automatic send_item(logic op, ticks_type ticks, cnt_type count, cnt_type reload);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.op <= op;
      req_ch.idle_ticks <= ticks;
      req_ch.count_value <= count;
      req_ch.current_reload <= reload;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Drop valid and wait until every result is back and the block is quiet
   task automatic settle();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, cnt_type data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= data;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(cnt_type period, min_type min_ticks);
      write_reg(CSR_TICK_PERIOD, period);
      write_reg(CSR_MIN_IDLE, {8'($urandom_range(255)), min_ticks});
      cfg_period = period;
      cfg_min = min_ticks;
      settings_used++;
   endtask

   // Pick a register setting; extremes come up in a fixed rotation
   task automatic pick_setting(int k);
      case (k % 6)
         0: apply_setting(cnt_type'($urandom_range(1, 2000)), min_type'($urandom_range(0, 4)));
         1: apply_setting(cnt_type'(1), min_type'(0));
         2: apply_setting(CNT_MAX, min_type'(16'hFFFF));
         3: apply_setting(cnt_type'($urandom), min_type'($urandom));
         4: apply_setting(cnt_type'(0), min_type'(1));
         default: apply_setting(cnt_type'($urandom_range(1000, 200000)),
                                min_type'($urandom_range(0, 20)));
      endcase
   endtask

   // Enter with tick counts spread around the minimum and out to the extremes
   task automatic send_enter();
      ticks_type ticks;
      cnt_type   count;
      case ($urandom_range(9))
         0, 1: ticks = ticks_type'(cfg_min) + ticks_type'($urandom_range(4)) - ticks_type'(2);
         2, 3, 4: ticks = ticks_type'(cfg_min) + ticks_type'($urandom_range(0, 300));
         5: ticks = ticks_type'($urandom_range(0, 20));
         6: ticks = ticks_type'($urandom);
         7: ticks = ($urandom_range(1) == 0) ? ticks_type'(1) : '1;
         default: ticks = ticks_type'($urandom_range(1, 100000));
      endcase
      case ($urandom_range(4))
         0: count = cnt_type'($urandom);
         1: count = ($urandom_range(1) == 0) ? cnt_type'(0) : CNT_MAX;
         2: count = cnt_type'($urandom_range(0, 255));
         default: count = (cfg_period == '0) ? cnt_type'(0)
                                             : cnt_type'($urandom_range(0, cfg_period));
      endcase
      send_item(OP_ENTER, ticks, count, cnt_type'($urandom));
   endtask

   // Exit with a remaining count mostly well below the programmed load
   task automatic send_exit();
      cnt_type count;
      count = cnt_type'($urandom) >> $urandom_range(0, 23);
      if ($urandom_range(15) == 0) begin
         count = '0;
      end
      send_item(OP_EXIT, ticks_type'($urandom), count, cnt_type'($urandom));
   endtask

   // Mostly enter/exit pairs, the rest random items in any order
   task automatic run_segment();
      int n;
      n = 0;
      while (n < SEGMENT_ITEMS) begin
         if ($urandom_range(9) < 8) begin
            send_enter();
            send_exit();
            n += 2;
         end else begin
            send_item(logic'($urandom_range(1)), ticks_type'($urandom), cnt_type'($urandom),
                      cnt_type'($urandom));
            n++;
         end
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.op <= OP_ENTER;
      req_ch.idle_ticks <= '0;
      req_ch.count_value <= '0;
      req_ch.current_reload <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.index <= CSR_TICK_PERIOD;
      csr_ch.data <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset registers, exit while awake, short idles, saturation, re-arm
      send_item(OP_EXIT, 32'h0000_1234, 24'h00_0100, 24'h00_0200);
      send_item(OP_ENTER, 32'd1, 24'h00_1000, 24'h00_1111);
      send_item(OP_ENTER, 32'd0, 24'h00_0000, 24'h00_2222);
      send_item(OP_ENTER, 32'd2, 24'd1000, 24'hFF_FFFF);
      send_item(OP_EXIT, 32'd0, 24'd0, 24'd0);
      send_item(OP_ENTER, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'h00_0001);
      send_item(OP_ENTER, 32'd100, 24'd0, 24'h12_3456);
      send_item(OP_EXIT, 32'hFFFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF);
      send_item(OP_EXIT, 32'd0, 24'd0, 24'd0);
      settle();

      // Zero period and no minimum: a zero-length sleep gives a one-shot load of zero
      write_reg(CSR_UNMAPPED, cnt_type'($urandom));
      apply_setting(cnt_type'(0), min_type'(0));
      send_item(OP_ENTER, 32'd0, 24'd0, 24'h55_AAAA);
      send_item(OP_EXIT, 32'd0, 24'd0, 24'd0);
      send_item(OP_ENTER, 32'd1, 24'hFF_FFFF, 24'hAA_5555);
      send_item(OP_EXIT, 32'd0, 24'd5, 24'd0);
      send_item(OP_ENTER, 32'd3, 24'd5, 24'h00_0007);
      send_item(OP_EXIT, 32'd0, 24'd0, 24'd0);
      settle();

      // Largest period and minimum
      apply_setting(CNT_MAX, min_type'(16'hFFFF));
      send_item(OP_ENTER, 32'h0000_FFFE, 24'd0, 24'h0F_0F0F);
      send_item(OP_ENTER, 32'h0000_FFFF, 24'd0, 24'hF0_F0F0);
      send_item(OP_EXIT, 32'd0, 24'd0, 24'd0);
      send_item(OP_EXIT, 32'd0, 24'd0, 24'd0);

      // Random phases under three idle mixes, with a new setting per segment
      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin
               send_idle_pct = 24;
               recv_idle_pct = 69;
            end
            1: begin
               send_idle_pct = 69;
               recv_idle_pct = 24;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int s = 0; s < SEGMENTS; s++) begin
            settle();
            pick_setting(p * SEGMENTS + s);
            if (s == 1) begin
               -> hold_rsp;
            end
            run_segment();
         end
      end

      // Drain, then give the verdict
      send_idle_pct = 0;
      recv_idle_pct = 0;
      settle();
      $display({"Sent %0d items over %0d register settings: %0d sleeps armed ",
                "(%0d clipped), %0d wakeups, %0d enters below minimum"},
               items_sent, settings_used, sleeps_armed, loads_clipped, wakeups, short_idles);
      $display({"Idle mixes covered: sender 24%%/receiver 69%%, then 69%%/24%%, ",
                "then none; %0d mismatches"},
               mismatches);
      if (mismatches == 0 && outstanding == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
